// File: rtl/t4ws_pkg.sv
// ----------------------------------------------------------------------------
// t4ws_pkg: shared types and constants for the top-4 weight selector
// Candidate record, sorted list type, request/response structs and the
// ranking order used by the lane sorters and the merge units.
// ----------------------------------------------------------------------------
package t4ws_pkg;

  localparam int NumClassesDef = 16;
  localparam int WeightBitsDef = 16;
  localparam int NumLanes      = 4;
  localparam int LaneClasses   = 4;
  localparam int TopK          = 4;
  localparam int ClsW          = 5;
  localparam int WeightW       = 16;
  localparam int FieldW        = 64;

  typedef struct packed {
    logic               vld;
    logic [WeightW-1:0] w;
    logic [ClsW-1:0]    cls;
  } cand_t;

  typedef cand_t [TopK-1:0] list_t;

  typedef struct packed {
    logic [FieldW-1:0] weights_lo;
    logic [FieldW-1:0] weights_mid_lo;
    logic [FieldW-1:0] weights_mid_hi;
    logic [FieldW-1:0] weights_hi;
  } req_t;

  typedef struct packed {
    logic               covered;
    logic [ClsW-1:0]    first_class;
    logic [WeightW-1:0] first_weight;
    logic [ClsW-1:0]    second_class;
    logic [WeightW-1:0] second_weight;
    logic [ClsW-1:0]    third_class;
    logic [WeightW-1:0] third_weight;
    logic [ClsW-1:0]    fourth_class;
    logic [WeightW-1:0] fourth_weight;
  } rsp_t;

  // Total order: valid first, then heavier, then lower class number.
  function automatic logic beats(cand_t a, cand_t b);
    logic res;
    if (a.vld != b.vld) begin
      res = a.vld;
    end else if (a.w != b.w) begin
      res = a.w > b.w;
    end else begin
      res = a.cls < b.cls;
    end
    return res;
  endfunction

endpackage

// File: rtl/t4ws_lane_sort.sv
// ----------------------------------------------------------------------------
// t4ws_lane_sort: four-class lane sorter
// Masks and clamps the four weights of one 64-bit field and orders them
// into a ranked list by pairwise comparison.
// ----------------------------------------------------------------------------
module t4ws_lane_sort #(
  parameter int NUM_CLASSES = t4ws_pkg::NumClassesDef,
  parameter int WEIGHT_BITS = t4ws_pkg::WeightBitsDef,
  parameter int LANE        = 0
) (
  input  logic [t4ws_pkg::FieldW-1:0] raw_i,
  output t4ws_pkg::list_t             list_o
);

  localparam int LC = t4ws_pkg::LaneClasses;
  localparam logic [t4ws_pkg::WeightW-1:0] Mask =
    t4ws_pkg::WeightW'((32'd1 << WEIGHT_BITS) - 32'd1);
  localparam logic [t4ws_pkg::WeightW-1:0] One =
    t4ws_pkg::WeightW'(32'd1 << (WEIGHT_BITS - 1));

  t4ws_pkg::cand_t cand [LC];
  logic [1:0]      rank [LC];

  always_comb begin
    for (int i = 0; i < LC; i++) begin
      logic [t4ws_pkg::WeightW-1:0] v;
      v = raw_i[i*t4ws_pkg::WeightW +: t4ws_pkg::WeightW] & Mask;
      cand[i].vld = (LANE * LC + i) < NUM_CLASSES;
      cand[i].w   = cand[i].vld ? ((v > One) ? One : v) : '0;
      cand[i].cls = t4ws_pkg::ClsW'(LANE * LC + i + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < LC; i++) begin
      rank[i] = '0;
      for (int j = 0; j < LC; j++) begin
        if (j != i && t4ws_pkg::beats(cand[j], cand[i])) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
  end

  always_comb begin
    list_o = '0;
    for (int k = 0; k < t4ws_pkg::TopK; k++) begin
      for (int i = 0; i < LC; i++) begin
        if (rank[i] == 2'(k)) begin
          list_o[k] = cand[i];
        end
      end
    end
  end

endmodule

// File: rtl/t4ws_merge.sv
// ----------------------------------------------------------------------------
// t4ws_merge: ranked list merge
// Combines two ranked lists and keeps the four leading candidates.
// ----------------------------------------------------------------------------
module t4ws_merge (
  input  t4ws_pkg::list_t a_i,
  input  t4ws_pkg::list_t b_i,
  output t4ws_pkg::list_t list_o
);

  localparam int K = t4ws_pkg::TopK;

  logic [2:0] rank_a [K];
  logic [2:0] rank_b [K];

  always_comb begin
    for (int i = 0; i < K; i++) begin
      rank_a[i] = 3'(i);
      rank_b[i] = 3'(i);
      for (int j = 0; j < K; j++) begin
        if (t4ws_pkg::beats(b_i[j], a_i[i])) begin
          rank_a[i] = rank_a[i] + 3'd1;
        end
        if (t4ws_pkg::beats(a_i[j], b_i[i])) begin
          rank_b[i] = rank_b[i] + 3'd1;
        end
      end
    end
  end

  always_comb begin
    list_o = '0;
    for (int k = 0; k < K; k++) begin
      for (int i = 0; i < K; i++) begin
        if (rank_a[i] == 3'(k)) begin
          list_o[k] = a_i[i];
        end
        if (rank_b[i] == 3'(k)) begin
          list_o[k] = b_i[i];
        end
      end
    end
  end

endmodule

// File: rtl/top4_of_16_weight_select.sv
// ----------------------------------------------------------------------------
// top4_of_16_weight_select: per-pixel top-4 class selector
// Four lane sorters rank the classes of each field, two merge levels pick the
// four heaviest classes, and an output register presents the response.
// ----------------------------------------------------------------------------
// One request per cycle unless a stalled response backs the pipeline up. The
// pipeline is lane sort, first merge level, final merge with the covered check;
// each ends in a register. A stalled response holds only the stages behind it
// that are full, so empty stages still take requests.
module top4_of_16_weight_select #(
  parameter int NUM_CLASSES = t4ws_pkg::NumClassesDef,
  parameter int WEIGHT_BITS = t4ws_pkg::WeightBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  t4ws_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output t4ws_pkg::rsp_t   out_rsp_o
);

  localparam int NL = t4ws_pkg::NumLanes;

  logic [t4ws_pkg::FieldW-1:0] lane_raw [NL];
  t4ws_pkg::list_t lane_list [NL];
  t4ws_pkg::list_t s1_d [NL];
  t4ws_pkg::list_t s1_q [NL];
  t4ws_pkg::list_t s2_d [2];
  t4ws_pkg::list_t s2_q [2];
  t4ws_pkg::list_t top_list;
  t4ws_pkg::rsp_t  rsp_d;
  t4ws_pkg::rsp_t  rsp_q;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;
  assign out_rsp_o   = rsp_q;

  assign lane_raw[0] = in_req_i.weights_lo;
  assign lane_raw[1] = in_req_i.weights_mid_lo;
  assign lane_raw[2] = in_req_i.weights_mid_hi;
  assign lane_raw[3] = in_req_i.weights_hi;

  for (genvar l = 0; l < NL; l++) begin : g_lane
    t4ws_lane_sort #(
      .NUM_CLASSES(NUM_CLASSES),
      .WEIGHT_BITS(WEIGHT_BITS),
      .LANE(l)
    ) u_lane (
      .raw_i (lane_raw[l]),
      .list_o(lane_list[l])
    );
    assign s1_d[l] = lane_list[l];
  end

  for (genvar m = 0; m < 2; m++) begin : g_merge
    t4ws_merge u_merge (
      .a_i   (s1_q[2*m]),
      .b_i   (s1_q[2*m+1]),
      .list_o(s2_d[m])
    );
  end

  t4ws_merge u_merge_final (
    .a_i   (s2_q[0]),
    .b_i   (s2_q[1]),
    .list_o(top_list)
  );

  always_comb begin
    rsp_d = '0;
    if (top_list[0].w != '0) begin
      rsp_d.covered       = 1'b1;
      rsp_d.first_class   = top_list[0].cls;
      rsp_d.first_weight  = top_list[0].w;
      rsp_d.second_class  = top_list[1].cls;
      rsp_d.second_weight = top_list[1].w;
      rsp_d.third_class   = top_list[2].cls;
      rsp_d.third_weight  = top_list[2].w;
      rsp_d.fourth_class  = top_list[3].cls;
      rsp_d.fourth_weight = top_list[3].w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) rsp_q <= rsp_d;
  end

endmodule

// File: rtl/t4ws_checker.sv
// ----------------------------------------------------------------------------
// t4ws_checker: port checker for the top-4 weight selector
// Checks responses: held on stall, ordered, distinct, cleared if uncovered.
// ----------------------------------------------------------------------------
module t4ws_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input t4ws_pkg::rsp_t out_rsp_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped or changed while stalled");

  a_uncovered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.covered |->
      out_rsp_o.first_class == '0 && out_rsp_o.first_weight == '0 &&
      out_rsp_o.second_class == '0 && out_rsp_o.second_weight == '0 &&
      out_rsp_o.third_class == '0 && out_rsp_o.third_weight == '0 &&
      out_rsp_o.fourth_class == '0 && out_rsp_o.fourth_weight == '0)
    else $error("uncovered response not cleared");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.covered |->
      out_rsp_o.first_weight >= out_rsp_o.second_weight &&
      out_rsp_o.second_weight >= out_rsp_o.third_weight &&
      out_rsp_o.third_weight >= out_rsp_o.fourth_weight &&
      out_rsp_o.first_weight != '0)
    else $error("weights out of order");

  a_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.covered |->
      out_rsp_o.first_class != out_rsp_o.second_class &&
      out_rsp_o.first_class != out_rsp_o.third_class &&
      out_rsp_o.first_class != out_rsp_o.fourth_class &&
      out_rsp_o.second_class != out_rsp_o.third_class &&
      out_rsp_o.second_class != out_rsp_o.fourth_class &&
      out_rsp_o.third_class != out_rsp_o.fourth_class)
    else $error("class reported twice");

  a_first_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(in_fire) && !$past(in_fire, 2) && !$past(in_fire, 3)
      |=> !out_valid_o)
    else $error("response without request");

endmodule

bind top4_of_16_weight_select t4ws_checker u_t4ws_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);
